@@ hdl/jtsv_pkg.sv @@
// Shared constants, token and expectation codes, and the stack control bundle
// for the JSON token structure validator. No dependencies.
package jtsv_pkg;

	localparam int MAX_DEPTH = 32;
	localparam int ADDR_W    = $clog2(MAX_DEPTH);
	localparam int DEPTH_W   = $clog2(MAX_DEPTH + 1);
	localparam int NEST_W    = 6;
	localparam int LIMIT_W   = 6;
	localparam int TOKEN_W   = 3;
	localparam int STATUS_W  = 2;
	localparam int EXPECT_W  = 3;
	localparam int CMP_W     = (DEPTH_W > LIMIT_W) ? DEPTH_W : LIMIT_W;

	localparam logic [LIMIT_W-1:0] DEPTH_LIMIT_RESET = LIMIT_W'(20);

	// token codes
	localparam logic [TOKEN_W-1:0] TOK_OBJ_OPEN  = 3'd0;
	localparam logic [TOKEN_W-1:0] TOK_OBJ_CLOSE = 3'd1;
	localparam logic [TOKEN_W-1:0] TOK_ARR_OPEN  = 3'd2;
	localparam logic [TOKEN_W-1:0] TOK_ARR_CLOSE = 3'd3;
	localparam logic [TOKEN_W-1:0] TOK_COMMA     = 3'd4;
	localparam logic [TOKEN_W-1:0] TOK_COLON     = 3'd5;
	localparam logic [TOKEN_W-1:0] TOK_QUOTED    = 3'd6;
	localparam logic [TOKEN_W-1:0] TOK_UNQUOTED  = 3'd7;

	// expectation states
	localparam logic [EXPECT_W-1:0] EX_TOP       = 3'd0;
	localparam logic [EXPECT_W-1:0] EX_OBJ_FIRST = 3'd1;
	localparam logic [EXPECT_W-1:0] EX_KEY       = 3'd2;
	localparam logic [EXPECT_W-1:0] EX_COLON     = 3'd3;
	localparam logic [EXPECT_W-1:0] EX_VALUE     = 3'd4;
	localparam logic [EXPECT_W-1:0] EX_ARR_FIRST = 3'd5;
	localparam logic [EXPECT_W-1:0] EX_NEXT      = 3'd6;
	localparam logic [EXPECT_W-1:0] EX_DONE      = 3'd7;

	// result status codes
	localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
	localparam logic [STATUS_W-1:0] ST_VALID = 2'd1;
	localparam logic [STATUS_W-1:0] ST_ERROR = 2'd2;

	typedef struct packed {
		logic               push;
		logic               pop;
		logic               obj;
		logic [DEPTH_W-1:0] depth_cur;
		logic [DEPTH_W-1:0] depth_nxt;
	} stack_ctrl_t;

endpackage

@@ hdl/jtsv_ifs.sv @@
// Valid/ready channel interfaces: token input, result output, config write.
// Depends on jtsv_pkg for field widths.
interface jtsv_tok_if;
	logic                          valid;
	logic                          ready;
	logic [jtsv_pkg::TOKEN_W-1:0]  token_type;
	logic                          last_token;
	modport source (output valid, output token_type, output last_token, input ready);
	modport sink   (input valid, input token_type, input last_token, output ready);
endinterface

interface jtsv_res_if;
	logic                          valid;
	logic                          ready;
	logic [jtsv_pkg::STATUS_W-1:0] status;
	logic [jtsv_pkg::NEST_W-1:0]   nesting_depth;
	modport source (output valid, output status, output nesting_depth, input ready);
	modport sink   (input valid, input status, input nesting_depth, output ready);
endinterface

interface jtsv_cfg_if;
	logic                          valid;
	logic                          ready;
	logic [jtsv_pkg::LIMIT_W-1:0]  depth_limit;
	modport source (output valid, output depth_limit, input ready);
	modport sink   (input valid, input depth_limit, output ready);
endinterface

@@ hdl/jtsv_stack.sv @@
// One-bit context stack: top entry in a register, lower entries in a
// synchronous memory with a registered read. Depends on jtsv_pkg.
module jtsv_stack (
	input  logic                  clk,
	input  logic                  arst_n,
	input  jtsv_pkg::stack_ctrl_t ctrl,
	output logic                  tos
);

	logic                          mem [jtsv_pkg::MAX_DEPTH];
	logic                          rd_q;
	logic                          tos_q;
	logic                          fwd_q;
	logic                          fwd_sel_q;
	logic                          below;
	logic                          wr_en;
	logic [jtsv_pkg::ADDR_W-1:0]   wr_addr;
	logic [jtsv_pkg::ADDR_W-1:0]   rd_addr;
	logic [jtsv_pkg::DEPTH_W-1:0]  wr_full;
	logic [jtsv_pkg::DEPTH_W-1:0]  rd_full;

	// spill the old top on a push; prefetch the entry just below the new top
	assign wr_full = ctrl.depth_cur - jtsv_pkg::DEPTH_W'(1);
	assign rd_full = ctrl.depth_nxt - jtsv_pkg::DEPTH_W'(2);
	assign wr_en   = ctrl.push && (ctrl.depth_cur != '0);
	assign wr_addr = wr_full[jtsv_pkg::ADDR_W-1:0];
	assign rd_addr = rd_full[jtsv_pkg::ADDR_W-1:0];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= tos_q;
		end
		rd_q <= mem[rd_addr];
	end

	// the spilled entry is read before it lands; forward it in the cycle after the push
	always_ff @(posedge clk) begin
		fwd_q <= tos_q;
		if (ctrl.push) begin
			tos_q <= ctrl.obj;
		end else if (ctrl.pop) begin
			tos_q <= below;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fwd_sel_q <= 1'b0;
		end else begin
			fwd_sel_q <= ctrl.push;
		end
	end

	assign below = fwd_sel_q ? fwd_q : rd_q;
	assign tos   = tos_q;

endmodule

@@ hdl/json_token_structure_validator.sv @@
// Top level of the JSON token structure validator.
// Depends on jtsv_pkg, the channel interfaces in jtsv_ifs.sv and jtsv_stack.
//
// Usage:
//  tok  - one lexed token per beat (token_type, last_token). Accepted when
//         valid and ready are both high.
//  res  - one result beat per token: status (0 fine so far, 1 document
//         complete and valid, 2 structure error) and nesting_depth after
//         the token.
//  cfg  - writes depth_limit (reset value 20); write only while idle.
//  Output: each result is registered and appears in the cycle after its beat.
//  Throughput: one token per cycle while the result is not stalled. The state
//  update is a single read-modify-write on the context stack: the top entry
//  sits in a register and the entry below it is prefetched from the stack
//  memory every cycle, with a forward path covering a push followed by a pop.
//  A stalled result holds in the output register; tok.ready drops only while
//  that register is full and res.ready is low.
//  Reset clears depth, error and expectation state and restores depth_limit;
//  no clearing pass is needed, the stack memory is read only below the
//  current depth. After a token marked last the document state clears.
module json_token_structure_validator (
	input  logic       clk,
	input  logic       arst_n,
	jtsv_tok_if.sink   tok,
	jtsv_res_if.source res,
	jtsv_cfg_if.sink   cfg
);

	// configuration
	logic [jtsv_pkg::LIMIT_W-1:0]   limit_q;

	// document state
	logic [jtsv_pkg::DEPTH_W-1:0]   depth_q;
	logic [jtsv_pkg::EXPECT_W-1:0]  ex_q;
	logic                           err_q;

	// output register
	logic                           res_valid_q;
	logic [jtsv_pkg::STATUS_W-1:0]  res_status_q;
	logic [jtsv_pkg::NEST_W-1:0]    res_depth_q;

	// step logic
	logic                           acc;
	logic                           tos;
	logic [jtsv_pkg::TOKEN_W-1:0]   t;
	logic                           is_open;
	logic                           is_close;
	logic                           is_word;
	logic                           open_obj;
	logic                           close_obj;
	logic                           open_ok;
	logic                           close_ok;
	logic                           want_open;
	logic                           want_close;
	logic                           ok;
	logic                           push_c;
	logic                           pop_c;
	logic [jtsv_pkg::EXPECT_W-1:0]  ex_nxt;
	logic [jtsv_pkg::EXPECT_W-1:0]  ex_after;
	logic [jtsv_pkg::DEPTH_W-1:0]   depth_after;
	logic                           err_now;
	logic [jtsv_pkg::STATUS_W-1:0]  status_c;
	jtsv_pkg::stack_ctrl_t          sctl;

	assign tok.ready = !res_valid_q || res.ready;
	assign cfg.ready = 1'b1;
	assign acc       = tok.valid && tok.ready;
	assign t         = tok.token_type;

	// token classes
	assign open_obj  = (t == jtsv_pkg::TOK_OBJ_OPEN);
	assign is_open   = open_obj || (t == jtsv_pkg::TOK_ARR_OPEN);
	assign close_obj = (t == jtsv_pkg::TOK_OBJ_CLOSE);
	assign is_close  = close_obj || (t == jtsv_pkg::TOK_ARR_CLOSE);
	assign is_word   = (t == jtsv_pkg::TOK_QUOTED) || (t == jtsv_pkg::TOK_UNQUOTED);

	// depth bound is the smaller of depth_limit and the stack size
	assign open_ok  = (depth_q != jtsv_pkg::DEPTH_W'(jtsv_pkg::MAX_DEPTH)) &&
	                  (jtsv_pkg::CMP_W'(depth_q) < jtsv_pkg::CMP_W'(limit_q));
	// a close must match the kind of the innermost open level
	assign close_ok = (depth_q != '0) && (tos == close_obj);

	// expectation automaton
	always_comb begin
		ok         = 1'b0;
		want_open  = 1'b0;
		want_close = 1'b0;
		push_c     = 1'b0;
		pop_c      = 1'b0;
		ex_nxt     = ex_q;
		unique case (ex_q)
			jtsv_pkg::EX_TOP: begin
				want_open = is_open;
			end
			jtsv_pkg::EX_OBJ_FIRST: begin
				want_close = close_obj;
				if (t == jtsv_pkg::TOK_QUOTED) begin
					ok     = 1'b1;
					ex_nxt = jtsv_pkg::EX_COLON;
				end
			end
			jtsv_pkg::EX_KEY: begin
				if (t == jtsv_pkg::TOK_QUOTED) begin
					ok     = 1'b1;
					ex_nxt = jtsv_pkg::EX_COLON;
				end
			end
			jtsv_pkg::EX_COLON: begin
				if (t == jtsv_pkg::TOK_COLON) begin
					ok     = 1'b1;
					ex_nxt = jtsv_pkg::EX_VALUE;
				end
			end
			jtsv_pkg::EX_VALUE: begin
				want_open = is_open;
				if (is_word) begin
					ok     = 1'b1;
					ex_nxt = jtsv_pkg::EX_NEXT;
				end
			end
			jtsv_pkg::EX_ARR_FIRST: begin
				want_open  = is_open;
				want_close = (t == jtsv_pkg::TOK_ARR_CLOSE);
				if (is_word) begin
					ok     = 1'b1;
					ex_nxt = jtsv_pkg::EX_NEXT;
				end
			end
			jtsv_pkg::EX_NEXT: begin
				want_close = is_close;
				if ((t == jtsv_pkg::TOK_COMMA) && (depth_q != '0)) begin
					ok     = 1'b1;
					ex_nxt = tos ? jtsv_pkg::EX_KEY : jtsv_pkg::EX_VALUE;
				end
			end
			jtsv_pkg::EX_DONE: begin
				// trailing tokens after the top-level value are errors
				ok = 1'b0;
			end
			default: begin
				ok = 1'b0;
			end
		endcase
		if (want_open) begin
			ok     = open_ok;
			push_c = open_ok;
			if (open_ok) begin
				ex_nxt = open_obj ? jtsv_pkg::EX_OBJ_FIRST : jtsv_pkg::EX_ARR_FIRST;
			end
		end
		if (want_close) begin
			ok    = close_ok;
			pop_c = close_ok;
			if (close_ok) begin
				ex_nxt = (depth_q == jtsv_pkg::DEPTH_W'(1)) ? jtsv_pkg::EX_DONE
				                                           : jtsv_pkg::EX_NEXT;
			end
		end
	end

	// hold everything once an error has latched
	assign err_now  = err_q || !ok;
	assign ex_after = err_q ? ex_q : ex_nxt;
	always_comb begin
		depth_after = depth_q;
		if (!err_q && push_c) begin
			depth_after = depth_q + jtsv_pkg::DEPTH_W'(1);
		end else if (!err_q && pop_c) begin
			depth_after = depth_q - jtsv_pkg::DEPTH_W'(1);
		end
	end

	always_comb begin
		priority if (err_now) begin
			status_c = jtsv_pkg::ST_ERROR;
		end else if (tok.last_token) begin
			status_c = (ex_after == jtsv_pkg::EX_DONE) ? jtsv_pkg::ST_VALID
			                                           : jtsv_pkg::ST_ERROR;
		end else begin
			status_c = jtsv_pkg::ST_OK;
		end
	end

	// stack control: act only on an accepted beat
	always_comb begin
		sctl.push      = acc && !err_q && push_c;
		sctl.pop       = acc && !err_q && pop_c;
		sctl.obj       = open_obj;
		sctl.depth_cur = depth_q;
		if (!acc) begin
			sctl.depth_nxt = depth_q;
		end else if (tok.last_token) begin
			sctl.depth_nxt = '0;
		end else begin
			sctl.depth_nxt = depth_after;
		end
	end

	jtsv_stack u_stack (
		.clk    (clk),
		.arst_n (arst_n),
		.ctrl   (sctl),
		.tos    (tos)
	);

	// configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_q <= jtsv_pkg::DEPTH_LIMIT_RESET;
		end else if (cfg.valid && cfg.ready) begin
			limit_q <= cfg.depth_limit;
		end
	end

	// document state: advance on each beat, clear after the last token
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			depth_q <= '0;
			ex_q    <= jtsv_pkg::EX_TOP;
			err_q   <= 1'b0;
		end else if (acc) begin
			if (tok.last_token) begin
				depth_q <= '0;
				ex_q    <= jtsv_pkg::EX_TOP;
				err_q   <= 1'b0;
			end else begin
				depth_q <= depth_after;
				ex_q    <= ex_after;
				err_q   <= err_now;
			end
		end
	end

	// output register: load on accept, drop when taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (acc) begin
			res_valid_q <= 1'b1;
		end else if (res.ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			res_status_q <= status_c;
			res_depth_q  <= depth_after[jtsv_pkg::NEST_W-1:0];
		end
	end

	assign res.valid         = res_valid_q;
	assign res.status        = res_status_q;
	assign res.nesting_depth = res_depth_q;

endmodule

@@ hdl/jtsv_checker.sv @@
// Port-level assertions for the JSON token structure validator, bound to the
// top level. Depends on jtsv_pkg.
module jtsv_checker (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          tok_valid,
	input logic                          tok_ready,
	input logic                          res_valid,
	input logic                          res_ready,
	input logic [jtsv_pkg::STATUS_W-1:0] status,
	input logic [jtsv_pkg::NEST_W-1:0]   nesting_depth
);

	// a stalled result holds
	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid && $stable(status) && $stable(nesting_depth))
		else $error("result changed while stalled");

	// every accepted token yields a result beat next cycle
	a_tok_to_res: assert property (@(posedge clk) disable iff (!arst_n)
		tok_valid && tok_ready |=> res_valid)
		else $error("no result after accepted token");

	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> (status == jtsv_pkg::ST_OK) || (status == jtsv_pkg::ST_VALID) ||
		              (status == jtsv_pkg::ST_ERROR))
		else $error("illegal status code");

	// a complete document has closed every level
	a_valid_depth: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && (status == jtsv_pkg::ST_VALID) |-> nesting_depth == '0)
		else $error("valid document with open levels");

	a_depth_bound: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> nesting_depth <= jtsv_pkg::NEST_W'(jtsv_pkg::MAX_DEPTH))
		else $error("nesting depth beyond stack size");

endmodule

bind json_token_structure_validator jtsv_checker u_jtsv_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.tok_valid     (tok.valid),
	.tok_ready     (tok.ready),
	.res_valid     (res.valid),
	.res_ready     (res.ready),
	.status        (res.status),
	.nesting_depth (res.nesting_depth)
);
